### design/spcg_pkg.sv
// Package for the sine plasma cell generator.
// Holds the screen geometry, register index codes and the sine table.
// No dependencies; imported by sine_plasma_cell_generator_top.
package spcg_pkg;

  // Screen geometry: the cell at (SCREEN_COLS-1, SCREEN_ROWS-1) closes a frame
  localparam int unsigned SCREEN_COLS = 80;
  localparam int unsigned SCREEN_ROWS = 25;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned PH_W    = 8;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef logic [PH_W-1:0] phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ROW_STEP_A  = 4'd0,
    REG_ROW_STEP_B  = 4'd1,
    REG_COL_STEP_A  = 4'd2,
    REG_COL_STEP_B  = 4'd3,
    REG_SPEED_ROW_A = 4'd4,
    REG_SPEED_ROW_B = 4'd5,
    REG_SPEED_COL_A = 4'd6,
    REG_SPEED_COL_B = 4'd7
  } cfg_reg_t;

  localparam phase_t RST_ROW_STEP_A  = 8'd4;
  localparam phase_t RST_ROW_STEP_B  = 8'd9;
  localparam phase_t RST_COL_STEP_A  = 8'd3;
  localparam phase_t RST_COL_STEP_B  = 8'd7;
  localparam phase_t RST_SPEED_ROW_A = 8'd3;
  localparam phase_t RST_SPEED_ROW_B = 8'd251;
  localparam phase_t RST_SPEED_COL_A = 8'd2;
  localparam phase_t RST_SPEED_COL_B = 8'd253;

  // One full period of sine, offset to 0x80, descending first
  localparam logic [IDX_W-1:0] SIN_ROM [256] = '{
    8'h80, 8'h7d, 8'h7a, 8'h77, 8'h74, 8'h70, 8'h6d, 8'h6a, 8'h67, 8'h64, 8'h61, 8'h5e,
    8'h5b, 8'h58, 8'h55, 8'h52, 8'h4f, 8'h4d, 8'h4a, 8'h47, 8'h44, 8'h41, 8'h3f, 8'h3c,
    8'h39, 8'h37, 8'h34, 8'h32, 8'h2f, 8'h2d, 8'h2b, 8'h28, 8'h26, 8'h24, 8'h22, 8'h20,
    8'h1e, 8'h1c, 8'h1a, 8'h18, 8'h16, 8'h15, 8'h13, 8'h11, 8'h10, 8'h0f, 8'h0d, 8'h0c,
    8'h0b, 8'h0a, 8'h08, 8'h07, 8'h06, 8'h06, 8'h05, 8'h04, 8'h03, 8'h03, 8'h02, 8'h02,
    8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h02, 8'h02, 8'h02, 8'h03,
    8'h03, 8'h04, 8'h05, 8'h06, 8'h06, 8'h07, 8'h08, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0f,
    8'h10, 8'h11, 8'h13, 8'h15, 8'h16, 8'h18, 8'h1a, 8'h1c, 8'h1e, 8'h20, 8'h22, 8'h24,
    8'h26, 8'h28, 8'h2b, 8'h2d, 8'h2f, 8'h32, 8'h34, 8'h37, 8'h39, 8'h3c, 8'h3f, 8'h41,
    8'h44, 8'h47, 8'h4a, 8'h4d, 8'h4f, 8'h52, 8'h55, 8'h58, 8'h5b, 8'h5e, 8'h61, 8'h64,
    8'h67, 8'h6a, 8'h6d, 8'h70, 8'h74, 8'h77, 8'h7a, 8'h7d, 8'h80, 8'h83, 8'h86, 8'h89,
    8'h8c, 8'h90, 8'h93, 8'h96, 8'h99, 8'h9c, 8'h9f, 8'ha2, 8'ha5, 8'ha8, 8'hab, 8'hae,
    8'hb1, 8'hb3, 8'hb6, 8'hb9, 8'hbc, 8'hbf, 8'hc1, 8'hc4, 8'hc7, 8'hc9, 8'hcc, 8'hce,
    8'hd1, 8'hd3, 8'hd5, 8'hd8, 8'hda, 8'hdc, 8'hde, 8'he0, 8'he2, 8'he4, 8'he6, 8'he8,
    8'hea, 8'heb, 8'hed, 8'hef, 8'hf0, 8'hf1, 8'hf3, 8'hf4, 8'hf5, 8'hf6, 8'hf8, 8'hf9,
    8'hfa, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfd, 8'hfe, 8'hfe, 8'hfe, 8'hff, 8'hff, 8'hff,
    8'hff, 8'hff, 8'hff, 8'hff, 8'hfe, 8'hfe, 8'hfe, 8'hfd, 8'hfd, 8'hfc, 8'hfb, 8'hfa,
    8'hfa, 8'hf9, 8'hf8, 8'hf6, 8'hf5, 8'hf4, 8'hf3, 8'hf1, 8'hf0, 8'hef, 8'hed, 8'heb,
    8'hea, 8'he8, 8'he6, 8'he4, 8'he2, 8'he0, 8'hde, 8'hdc, 8'hda, 8'hd8, 8'hd5, 8'hd3,
    8'hd1, 8'hce, 8'hcc, 8'hc9, 8'hc7, 8'hc4, 8'hc1, 8'hbf, 8'hbc, 8'hb9, 8'hb6, 8'hb3,
    8'hb1, 8'hae, 8'hab, 8'ha8, 8'ha5, 8'ha2, 8'h9f, 8'h9c, 8'h99, 8'h96, 8'h93, 8'h90,
    8'h8c, 8'h89, 8'h86, 8'h83
  };

endpackage

### design/sine_plasma_cell_generator_top.sv
// Sine plasma cell generator, top level.
// Two register stages: table addresses, then sine lookups summed into the output.
// Depends on spcg_pkg (geometry, register codes, sine table).
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  in      | in  | in_tvalid/tready   | in_tdata: cell_col[6:0], cell_row[11:7], 0
//  out     | out | out_tvalid/tready  | out_tdata: char_index[7:0]; out_tlast
//  cfg     | in  | cfg_we             | cfg_addr (register index), cfg_wdata
//
// One item per clock sustained while out_tready stays high.
// Stage 1 holds the four table addresses (phase + position * step); stage 2 holds
// the sum of the four sine lookups. Each stage advances when it is empty or the
// stage after it moves, so a full pipeline stalls only while out_tready is low.
// rst_n (synchronous, active low) empties both stages, zeroes the four phases and
// loads the register reset values. Phases advance when the last cell is accepted.
module sine_plasma_cell_generator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [spcg_pkg::IN_TDATA_W-1:0]     in_tdata,   // cell_col[6:0], cell_row[11:7]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [spcg_pkg::OUT_TDATA_W-1:0]    out_tdata,  // char_index[7:0]
  output logic                                out_tlast,  // frame_last
  input  logic                                cfg_we,
  input  logic [spcg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [spcg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import spcg_pkg::*;

  // Configuration registers
  phase_t row_step_a_r, row_step_b_r, col_step_a_r, col_step_b_r;
  phase_t speed_ra_r, speed_rb_r, speed_ca_r, speed_cb_r;

  // Frame phases
  phase_t phase_ra_r, phase_rb_r, phase_ca_r, phase_cb_r;

  // Stage 1: table addresses
  logic   s1_valid_r;
  logic   s1_last_r;
  phase_t addr_ra_r, addr_rb_r, addr_ca_r, addr_cb_r;

  // Stage 2: output register
  logic             out_valid_r;
  logic             out_last_r;
  logic [IDX_W-1:0] out_index_r;

  logic [COL_W-1:0] cell_col;
  logic [ROW_W-1:0] cell_row;
  phase_t           col_ext, row_ext;
  logic             cell_last;
  logic             in_fire;
  logic             adv1, adv2;
  phase_t           addr_ra_nxt, addr_rb_nxt, addr_ca_nxt, addr_cb_nxt;
  logic [IDX_W-1:0] out_index_nxt;

  assign cell_col = in_tdata[COL_W-1:0];
  assign cell_row = in_tdata[COL_W+ROW_W-1:COL_W];
  assign col_ext  = {{(PH_W-COL_W){1'b0}}, cell_col};
  assign row_ext  = {{(PH_W-ROW_W){1'b0}}, cell_row};

  // Only the exact last position closes a frame; off-screen cells never do
  assign cell_last = (col_ext == PH_W'(SCREEN_COLS - 1)) &&
                     (row_ext == PH_W'(SCREEN_ROWS - 1));

  // Pipeline flow: each stage moves when empty or when downstream moves
  assign adv2      = !out_valid_r || out_tready;
  assign adv1      = !s1_valid_r || adv2;
  assign in_tready = adv1;
  assign in_fire   = in_tvalid && in_tready;

  // Products wrap mod 256 like the address itself
  assign addr_ra_nxt = phase_ra_r + PH_W'(row_ext * row_step_a_r);
  assign addr_rb_nxt = phase_rb_r + PH_W'(row_ext * row_step_b_r);
  assign addr_ca_nxt = phase_ca_r + PH_W'(col_ext * col_step_a_r);
  assign addr_cb_nxt = phase_cb_r + PH_W'(col_ext * col_step_b_r);

  assign out_index_nxt = SIN_ROM[addr_ra_r] + SIN_ROM[addr_rb_r] +
                         SIN_ROM[addr_ca_r] + SIN_ROM[addr_cb_r];

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_step_a_r <= RST_ROW_STEP_A;
      row_step_b_r <= RST_ROW_STEP_B;
      col_step_a_r <= RST_COL_STEP_A;
      col_step_b_r <= RST_COL_STEP_B;
      speed_ra_r   <= RST_SPEED_ROW_A;
      speed_rb_r   <= RST_SPEED_ROW_B;
      speed_ca_r   <= RST_SPEED_COL_A;
      speed_cb_r   <= RST_SPEED_COL_B;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ROW_STEP_A:  row_step_a_r <= cfg_wdata;
        REG_ROW_STEP_B:  row_step_b_r <= cfg_wdata;
        REG_COL_STEP_A:  col_step_a_r <= cfg_wdata;
        REG_COL_STEP_B:  col_step_b_r <= cfg_wdata;
        REG_SPEED_ROW_A: speed_ra_r   <= cfg_wdata;
        REG_SPEED_ROW_B: speed_rb_r   <= cfg_wdata;
        REG_SPEED_COL_A: speed_ca_r   <= cfg_wdata;
        REG_SPEED_COL_B: speed_cb_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Phases step at the edge that takes the last cell; the last cell itself has
  // already sampled the old phases into its addresses.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ra_r <= '0;
      phase_rb_r <= '0;
      phase_ca_r <= '0;
      phase_cb_r <= '0;
    end else if (in_fire && cell_last) begin
      phase_ra_r <= phase_ra_r + speed_ra_r;
      phase_rb_r <= phase_rb_r + speed_rb_r;
      phase_ca_r <= phase_ca_r + speed_ca_r;
      phase_cb_r <= phase_cb_r + speed_cb_r;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_last_r <= cell_last;
      addr_ra_r <= addr_ra_nxt;
      addr_rb_r <= addr_rb_nxt;
      addr_ca_r <= addr_ca_nxt;
      addr_cb_r <= addr_cb_nxt;
    end
  end

  // Stage 2: output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_index_r <= out_index_nxt;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_index_r;
  assign out_tlast  = out_last_r;

  // Phases move only on an accepted last cell (checked on phase_ra_r and phase_cb_r)
  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && cell_last) |=> $stable(phase_ra_r) && $stable(phase_cb_r))
    else $error("phase changed without a last cell");

  // Input back-pressure only when both stages are full and the output stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled with room in the pipeline");

  // A new result can only come from a filled stage 1
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("output valid without a stage 1 item");

endmodule

### verif/tb.sv
// Self-checking testbench for sine_plasma_cell_generator_top.
// Holds its own plasma predictor, a directed stimulus table, random raster scans and checks.
// Depends on spcg_pkg (widths, register codes, reset values, sine table) and the top level.
module tb;
  import spcg_pkg::*;

  // Two pipeline stages; the drain wait lets the pipe settle before a register load
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned NUM_REGS        = 8;
  localparam int unsigned UNUSED_REG_BASE = NUM_REGS;  // indexes 8..15 decode to nothing
  localparam int unsigned FRAME_CELLS     = SCREEN_COLS * SCREEN_ROWS;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned CELLS_PER_PHASE = 155;
  localparam int unsigned LONG_HOLD       = 60;
  localparam int unsigned MAX_WAIT        = 10;

  typedef struct packed {
    logic [IDX_W-1:0] char_index;
    logic             frame_last;
  } plasma_result_t;

  // Directed table: either one cell, or a load of the same value into every register
  typedef enum logic {ROW_CELL, ROW_LOAD} row_kind_t;
  typedef struct {
    row_kind_t kind;
    int        col;
    int        row;
    int        load_val;
    bit        typed;      // expected result written in the table
    int        exp_index;
    bit        exp_last;
  } stim_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // cell_col[6:0], cell_row[11:7], zero fill
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // char_index[7:0]
  logic                   out_tlast;  // frame_last
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  sine_plasma_cell_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: register copy and the four frame phases
  phase_t cfg_shadow [NUM_REGS];
  phase_t rphase_a, rphase_b, cphase_a, cphase_b;

  plasma_result_t pending_results [$];
  stim_row_t      directed [];

  int unsigned n_errors;
  int unsigned n_cells;
  int unsigned n_frames;
  int unsigned n_loads;
  int unsigned cycles;

  // Idling controls shared between the stimulus and the receiver
  bit sender_gapless;
  bit receiver_gapless;
  bit hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit; generous against the slowest correct run (every item waiting out
  // both the longest sender gap and the longest receiver stall)
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Plasma value of one cell from the current phases, then the frame advance
  // when the cell is the bottom-right one. Table addresses wrap at 8 bits.
  function automatic plasma_result_t next_plasma_cell(logic [COL_W-1:0] col,
                                                     logic [ROW_W-1:0] row);
    plasma_result_t r;
    phase_t a_ra, a_rb, a_ca, a_cb;
    logic [IDX_W-1:0] sum;
    a_ra = rphase_a + phase_t'(row) * cfg_shadow[REG_ROW_STEP_A];
    a_rb = rphase_b + phase_t'(row) * cfg_shadow[REG_ROW_STEP_B];
    a_ca = cphase_a + phase_t'(col) * cfg_shadow[REG_COL_STEP_A];
    a_cb = cphase_b + phase_t'(col) * cfg_shadow[REG_COL_STEP_B];
    sum  = SIN_ROM[a_ra] + SIN_ROM[a_rb] + SIN_ROM[a_ca] + SIN_ROM[a_cb];
    r.char_index = sum;
    r.frame_last = (col == COL_W'(SCREEN_COLS - 1)) && (row == ROW_W'(SCREEN_ROWS - 1));
    // The result keeps the old phases; the advance applies from the next cell on
    if (r.frame_last) begin
      rphase_a = rphase_a + cfg_shadow[REG_SPEED_ROW_A];
      rphase_b = rphase_b + cfg_shadow[REG_SPEED_ROW_B];
      cphase_a = cphase_a + cfg_shadow[REG_SPEED_COL_A];
      cphase_b = cphase_b + cfg_shadow[REG_SPEED_COL_B];
      n_frames++;
    end
    return r;
  endfunction

  function automatic int unsigned draw_wait(bit gapless);
    return gapless ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Extremes are drawn often so that 0 and 255 show up in the registers
  function automatic phase_t rand_reg_val();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return phase_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One cell on the input channel. Called and returns at a falling edge.
  // The expectation is pushed at the accepting rising edge.
  task automatic send_cell(int col, int row, bit typed = 1'b0,
                           int exp_index = 0, bit exp_last = 1'b0);
    int unsigned gap;
    plasma_result_t r;
    gap = draw_wait(sender_gapless);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({ROW_W'(row), COL_W'(col)});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = next_plasma_cell(COL_W'(col), ROW_W'(row));
    if (typed) begin
      r.char_index = IDX_W'(exp_index);
      r.frame_last = exp_last;
    end
    pending_results.push_back(r);
    n_cells++;
    @(negedge clk);
  endtask

  // Stop offering, let every expected item come back, then let the pipe settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write all eight registers, then poke one index that decodes to nothing
  task automatic load_regs(input phase_t vals [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      cfg_shadow[i] = vals[i];
      @(negedge clk);
    end
    cfg_addr  <= CFG_ADDR_W'(UNUSED_REG_BASE + $urandom_range(0, 7));
    cfg_wdata <= CFG_DATA_W'($urandom_range(0, 255));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_loads++;
  endtask

  // Receiver: a random stall per item, or one long hold-off when asked
  initial begin
    int unsigned n;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        n = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        n = draw_wait(receiver_gapless);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Result checker: oldest expectation first
  always @(posedge clk) begin
    plasma_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected item: char_index %0h frame_last %0b", out_tdata, out_tlast);
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_tdata[IDX_W-1:0] !== e.char_index) begin
          $error("char_index: expected %0h, got %0h", e.char_index, out_tdata[IDX_W-1:0]);
          n_errors++;
        end
        if (out_tlast !== e.frame_last) begin
          $error("frame_last: expected %0b, got %0b", e.frame_last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    phase_t regs [NUM_REGS];
    int unsigned budget, burst, pos;
    int col, row;

    // Every input known from time zero
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    n_errors   = 0;
    n_cells    = 0;
    n_frames   = 0;
    n_loads    = 0;
    cycles     = 0;
    sender_gapless   = 1'b0;
    receiver_gapless = 1'b0;
    hold_off_req     = 1'b0;

    cfg_shadow[REG_ROW_STEP_A]  = RST_ROW_STEP_A;
    cfg_shadow[REG_ROW_STEP_B]  = RST_ROW_STEP_B;
    cfg_shadow[REG_COL_STEP_A]  = RST_COL_STEP_A;
    cfg_shadow[REG_COL_STEP_B]  = RST_COL_STEP_B;
    cfg_shadow[REG_SPEED_ROW_A] = RST_SPEED_ROW_A;
    cfg_shadow[REG_SPEED_ROW_B] = RST_SPEED_ROW_B;
    cfg_shadow[REG_SPEED_COL_A] = RST_SPEED_COL_A;
    cfg_shadow[REG_SPEED_COL_B] = RST_SPEED_COL_B;
    rphase_a = '0;
    rphase_b = '0;
    cphase_a = '0;
    cphase_b = '0;

    // Directed part. With phases at zero every lookup of address 0 gives 0x80,
    // so four of them sum to 0x00; zero steps keep every address at the phase.
    directed = '{
      '{ROW_CELL,   0,  0,    0, 1'b1, 8'h00, 1'b0},  // after reset, origin
      '{ROW_CELL, 127, 31,    0, 1'b0, 0,     1'b0},  // both fields at all ones
      '{ROW_CELL,   0, 31,    0, 1'b0, 0,     1'b0},
      '{ROW_CELL, 127,  0,    0, 1'b0, 0,     1'b0},
      '{ROW_LOAD,   0,  0,    0, 1'b0, 0,     1'b0},  // all steps and speeds zero
      '{ROW_CELL, 127, 31,    0, 1'b1, 8'h00, 1'b0},
      '{ROW_CELL,  79, 24,    0, 1'b1, 8'h00, 1'b1},  // last cell, zero speeds
      '{ROW_CELL,  45, 17,    0, 1'b1, 8'h00, 1'b0},  // phases still zero
      '{ROW_LOAD,   0,  0,  255, 1'b0, 0,     1'b0},  // everything at 255
      '{ROW_CELL,  79, 24,    0, 1'b0, 0,     1'b0},  // last cell, advance
      '{ROW_CELL,  79, 24,    0, 1'b0, 0,     1'b0},  // repeated last cell
      '{ROW_CELL,   0,  0,    0, 1'b0, 0,     1'b0},
      '{ROW_CELL, 127, 31,    0, 1'b0, 0,     1'b0},
      '{ROW_CELL,  79, 23,    0, 1'b0, 0,     1'b0},  // next to the last cell
      '{ROW_CELL,  78, 24,    0, 1'b0, 0,     1'b0},
      '{ROW_CELL,  79, 31,    0, 1'b0, 0,     1'b0},  // row off screen, not last
      '{ROW_CELL,  85,  7,    0, 1'b0, 0,     1'b0},  // column off screen
      '{ROW_CELL,   1,  1,    0, 1'b0, 0,     1'b0},
      '{ROW_CELL,  64, 16,    0, 1'b0, 0,     1'b0}
    };

    // Synchronous reset, once
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_LOAD) begin
        wait_idle();
        foreach (regs[k]) regs[k] = phase_t'(directed[i].load_val);
        load_regs(regs);
      end else begin
        send_cell(directed[i].col, directed[i].row, directed[i].typed,
                  directed[i].exp_index, directed[i].exp_last);
      end
    end

    // Random part: one register setting per phase. The first phase goes back
    // to the reset values; the others mix extremes with random values.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p == 0) begin
        regs[REG_ROW_STEP_A]  = RST_ROW_STEP_A;
        regs[REG_ROW_STEP_B]  = RST_ROW_STEP_B;
        regs[REG_COL_STEP_A]  = RST_COL_STEP_A;
        regs[REG_COL_STEP_B]  = RST_COL_STEP_B;
        regs[REG_SPEED_ROW_A] = RST_SPEED_ROW_A;
        regs[REG_SPEED_ROW_B] = RST_SPEED_ROW_B;
        regs[REG_SPEED_COL_A] = RST_SPEED_COL_A;
        regs[REG_SPEED_COL_B] = RST_SPEED_COL_B;
      end else begin
        foreach (regs[k]) regs[k] = rand_reg_val();
      end
      load_regs(regs);

      // Phase 1 runs both sides back to back; phase 2 has the sender flat out
      // against a long receiver hold-off so the pipe fills and stalls its input
      sender_gapless   = (p == 1) || (p == 2);
      receiver_gapless = (p == 1);
      if (p == 2) hold_off_req = 1'b1;

      budget = 0;
      while (budget < CELLS_PER_PHASE) begin
        case ($urandom_range(0, 9)) inside
          [0:6]: begin
            // Raster burst, mostly running through the frame end and wrapping
            pos   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FRAME_CELLS - 1)
                                               : FRAME_CELLS - $urandom_range(1, 30);
            burst = $urandom_range(5, 40);
            for (int b = 0; b < burst; b++) begin
              send_cell(pos % SCREEN_COLS, pos / SCREEN_COLS);
              pos = (pos + 1) % FRAME_CELLS;
            end
            budget += burst;
          end
          [7:8]: begin
            send_cell($urandom_range(0, SCREEN_COLS - 1), $urandom_range(0, SCREEN_ROWS - 1));
            budget++;
          end
          default: begin
            // Anywhere the field widths allow, off screen included
            col = $urandom_range(0, (1 << COL_W) - 1);
            row = $urandom_range(0, (1 << ROW_W) - 1);
            send_cell(col, row);
            budget++;
          end
        endcase
      end
    end

    sender_gapless   = 1'b0;
    receiver_gapless = 1'b0;
    wait_idle();
    repeat (2 * DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d cells, %0d frame ends, %0d register loads incl. extremes",
             n_cells, n_frames, n_loads);
    $display("Cells spanned full-width fields, off-screen and repeated last cells, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
